FILE: sv/pas_pkg.sv
// Shared types and constants of the polyline area simplifier.
`timescale 1ns / 1ps

package pas_pkg;

    localparam int COORD_W        = 24;
    localparam int XY_W           = 2 * COORD_W;
    localparam int DELTA_W        = COORD_W + 1;
    localparam int AREA_W         = 51;
    localparam int TOL_W          = 24;
    localparam int MINP_W         = 7;
    localparam int CFG_IDX_W      = 2;
    localparam int CFG_DATA_W     = 24;
    localparam int DEF_MAX_POINTS = 64;

    localparam logic [CFG_IDX_W-1:0] REG_TOLERANCE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_POINTS = 2'd1;

    localparam logic [TOL_W-1:0]  TOL_RESET  = 24'd256;
    localparam logic [MINP_W-1:0] MINP_RESET = 7'd3;
    localparam logic [MINP_W-1:0] CLOSED_MIN = 7'd4;

    // Squared closing distance, 2.0 in Q16.8 squared.
    localparam logic [AREA_W-1:0] CLOSE_DIST_SQ = 51'd262144;

    // Last offset of the refresh after a removal, counted from two places before the removed point.
    localparam logic [2:0] RECOMP_LAST_OFF = 3'd4;

    typedef enum logic [4:0] {
        ST_LOAD,
        ST_START,
        ST_CLS_RD0,
        ST_CLS_RD1,
        ST_CLS_CAP,
        ST_CLS_WAIT,
        ST_INIT,
        ST_RC_CHK,
        ST_RC_RA,
        ST_RC_RB,
        ST_RC_RC,
        ST_RC_WAIT,
        ST_RC_RET,
        ST_SCAN_START,
        ST_SCAN,
        ST_SCAN_END,
        ST_OUT_RD,
        ST_OUT_CAP,
        ST_OUT_WAIT
    } pas_state_t;

    typedef enum logic [1:0] {
        AP_IDLE,
        AP_MUL1,
        AP_MUL2,
        AP_SUM
    } area_phase_t;

endpackage

FILE: sv/pas_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module pas_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: sv/pas_area.sv
// Multi-cycle |a*b - c*d| or |a*b + c*d| unit sharing one signed multiplier.
`timescale 1ns / 1ps

module pas_area (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                start,
    input  logic                                sum_mode,
    input  logic signed [pas_pkg::DELTA_W-1:0]  op_a,
    input  logic signed [pas_pkg::DELTA_W-1:0]  op_b,
    input  logic signed [pas_pkg::DELTA_W-1:0]  op_c,
    input  logic signed [pas_pkg::DELTA_W-1:0]  op_d,
    output logic                                done,
    output logic [pas_pkg::AREA_W-1:0]          result
);

    localparam int PROD_W = 2 * pas_pkg::DELTA_W;

    pas_pkg::area_phase_t phase_reg, phase_next;

    logic signed [pas_pkg::DELTA_W-1:0] mul_a, mul_b;
    logic signed [PROD_W-1:0]           prod;
    logic signed [PROD_W-1:0]           p_reg, q_reg;
    logic signed [PROD_W:0]             diff;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= pas_pkg::AP_IDLE;
        end else begin
            phase_reg <= phase_next;
        end
    end

    always_comb begin
        phase_next = phase_reg;
        unique case (phase_reg)
            pas_pkg::AP_IDLE: if (start) phase_next = pas_pkg::AP_MUL1;
            pas_pkg::AP_MUL1: phase_next = pas_pkg::AP_MUL2;
            pas_pkg::AP_MUL2: phase_next = pas_pkg::AP_SUM;
            pas_pkg::AP_SUM:  phase_next = pas_pkg::AP_IDLE;
            default:          phase_next = pas_pkg::AP_IDLE;
        endcase
    end

    assign mul_a = (phase_reg == pas_pkg::AP_MUL2) ? op_c : op_a;
    assign mul_b = (phase_reg == pas_pkg::AP_MUL2) ? op_d : op_b;
    assign prod  = mul_a * mul_b;

    always_ff @(posedge aclk) begin
        if (phase_reg == pas_pkg::AP_MUL1) begin
            p_reg <= prod;
        end
        if (phase_reg == pas_pkg::AP_MUL2) begin
            q_reg <= prod;
        end
    end

    always_comb begin
        if (sum_mode) begin
            diff = $signed({p_reg[PROD_W-1], p_reg}) + $signed({q_reg[PROD_W-1], q_reg});
        end else begin
            diff = $signed({p_reg[PROD_W-1], p_reg}) - $signed({q_reg[PROD_W-1], q_reg});
        end
    end

    assign result = diff[PROD_W] ? $unsigned(-diff) : $unsigned(diff);
    assign done   = (phase_reg == pas_pkg::AP_SUM);

endmodule

FILE: sv/polyline_area_simplifier.sv
// Top level of the polyline area simplifier (Visvalingam-Whyatt in fixed point).
`timescale 1ns / 1ps

// Points of a path are taken one per cycle and written into a coordinate RAM; once the
// request marked final_point is accepted the block stops taking points, simplifies the
// path and sends the surviving points, in their original order, one per request on the
// result channel, with end_of_path on the last one and overflow on every one if points
// past MAX_POINTS were dropped. Simplification first checks whether the path is closed
// (more than 3 points, ends closer than 2.0), then computes the doubled triangle area of
// every point that may be removed into an area RAM (three coordinate reads and then the
// shared multiply unit per point), and then repeats a removal round until nothing lies
// below 2*tolerance^2 or only the required minimum is left. One round is a scan of the
// area RAM (one entry per cycle through its single read port) plus the refresh of the
// five index places around the removed point. The next result is read only after the sink
// has taken the current one. Paths of at most min_points points skip simplification. The
// user must write the configuration port only while the block waits for points, which the
// block itself does not enforce; no clearing pass is needed after reset.

module polyline_area_simplifier #(
    parameter int MAX_POINTS = pas_pkg::DEF_MAX_POINTS
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // Configuration write port.
    input  logic                                cfg_we,
    input  logic [pas_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [pas_pkg::CFG_DATA_W-1:0]      cfg_data,
    // Point requests.
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic signed [pas_pkg::COORD_W-1:0]  s_px,
    input  logic signed [pas_pkg::COORD_W-1:0]  s_py,
    input  logic                                s_keep,
    input  logic                                s_final_point,
    // Result requests.
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic signed [pas_pkg::COORD_W-1:0]  m_qx,
    output logic signed [pas_pkg::COORD_W-1:0]  m_qy,
    output logic                                m_end_of_path,
    output logic                                m_overflow
);

    localparam int IW    = $clog2(MAX_POINTS);
    localparam int CW    = $clog2(MAX_POINTS + 1);
    localparam int CW_MP = pas_pkg::MINP_W;

    // Configuration registers.
    logic [pas_pkg::TOL_W-1:0]  tol_reg;
    logic [pas_pkg::MINP_W-1:0] minp_reg;

    // Control state.
    pas_pkg::pas_state_t  state_reg, state_next;
    logic [CW-1:0]         cnt_reg, cnt_next;
    logic                  dropped_reg, dropped_next;
    logic [MAX_POINTS-1:0] keep_reg, keep_next;
    logic [MAX_POINTS-1:0] removed_reg, removed_next;
    logic [MAX_POINTS-1:0] inf_reg, inf_next;
    logic                  closed_reg, closed_next;
    logic [CW-1:0]         remain_reg, remain_next;
    logic [CW-1:0]         loop_reg, loop_next;
    logic                  post_reg, post_next;
    logic [2:0]            off_reg, off_next;
    logic                  best_vld_reg, best_vld_next;
    logic                  cmp_vld_reg, cmp_vld_next;

    // Datapath registers.
    logic [pas_pkg::AREA_W-1:0]  thr_reg, thr_next;
    logic [pas_pkg::MINP_W-1:0]  need_reg, need_next;
    logic [IW-1:0]               idx_reg, idx_next;
    logic [IW-1:0]               nxt_reg, nxt_next;
    logic [IW-1:0]               best_reg, best_next;
    logic [IW-1:0]               cmp_idx_reg, cmp_idx_next;
    logic [pas_pkg::AREA_W-1:0]  best_area_reg, best_area_next;
    logic [pas_pkg::XY_W-1:0]    pa_reg, pa_next;
    logic [pas_pkg::XY_W-1:0]    pb_reg, pb_next;
    logic signed [pas_pkg::DELTA_W-1:0] dx1_reg, dx1_next, dy1_reg, dy1_next;
    logic signed [pas_pkg::DELTA_W-1:0] dx2_reg, dx2_next, dy2_reg, dy2_next;
    logic                        sum_mode_reg, sum_mode_next;
    logic [pas_pkg::COORD_W-1:0] qx_reg, qx_next, qy_reg, qy_next;
    logic                        eop_reg, eop_next;
    logic                        ovf_reg, ovf_next;

    // Memories.
    logic                       xy_we;
    logic [IW-1:0]              xy_waddr, xy_raddr;
    logic [pas_pkg::XY_W-1:0]   xy_wdata, xy_rdata;
    logic                       area_we;
    logic [IW-1:0]              area_raddr;
    logic [pas_pkg::AREA_W-1:0] area_rdata;

    // Area unit.
    logic                       area_start;
    logic                       area_done;
    logic [pas_pkg::AREA_W-1:0] area_res;

    // Neighbour and output search.
    logic [MAX_POINTS-1:0] alive;
    logic [IW-1:0]         prev_idx, next_idx, first_alive, last_alive, out_sel;
    logic                  prev_hit, next_hit, out_hit;
    logic [IW-1:0]         last_idx, inc_idx, dec1_idx, dec2_idx;
    logic [47:0]           tol_sq;
    logic                  s_acc;
    logic signed [pas_pkg::DELTA_W-1:0] rd_dx, rd_dy;

    pas_ram #(
        .WIDTH (pas_pkg::XY_W),
        .DEPTH (MAX_POINTS)
    ) u_xy_ram (
        .aclk  (aclk),
        .we    (xy_we),
        .waddr (xy_waddr),
        .wdata (xy_wdata),
        .raddr (xy_raddr),
        .rdata (xy_rdata)
    );

    pas_ram #(
        .WIDTH (pas_pkg::AREA_W),
        .DEPTH (MAX_POINTS)
    ) u_area_ram (
        .aclk  (aclk),
        .we    (area_we),
        .waddr (idx_reg),
        .wdata (area_res),
        .raddr (area_raddr),
        .rdata (area_rdata)
    );

    pas_area u_area (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (area_start),
        .sum_mode (sum_mode_reg),
        .op_a     (dx1_reg),
        .op_b     (dy2_reg),
        .op_c     (dx2_reg),
        .op_d     (dy1_reg),
        .done     (area_done),
        .result   (area_res)
    );

    // Configuration writes; indexes past the register list are ignored.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tol_reg  <= pas_pkg::TOL_RESET;
            minp_reg <= pas_pkg::MINP_RESET;
        end else if (cfg_we) begin
            if (cfg_index == pas_pkg::REG_TOLERANCE) begin
                tol_reg <= cfg_data;
            end else if (cfg_index == pas_pkg::REG_MIN_POINTS) begin
                minp_reg <= cfg_data[pas_pkg::MINP_W-1:0];
            end
        end
    end

    assign s_ready = (state_reg == pas_pkg::ST_LOAD);
    assign s_acc   = s_valid && s_ready;
    assign tol_sq  = tol_reg * tol_reg;

    // A point is alive while it is stored and not removed.
    always_comb begin
        for (int i = 0; i < MAX_POINTS; i++) begin
            alive[i] = !removed_reg[i] && (CW'(i) < cnt_reg);
        end
    end

    // Nearest alive neighbours of idx_reg, wrapping around the path, and the next
    // alive point at or after the output cursor.
    always_comb begin
        prev_hit    = 1'b0;
        next_hit    = 1'b0;
        out_hit     = 1'b0;
        prev_idx    = '0;
        next_idx    = '0;
        first_alive = '0;
        last_alive  = '0;
        out_sel     = '0;
        for (int i = 0; i < MAX_POINTS; i++) begin
            if (alive[i]) begin
                last_alive = IW'(i);
                if (IW'(i) < idx_reg) begin
                    prev_idx = IW'(i);
                    prev_hit = 1'b1;
                end
            end
        end
        for (int i = MAX_POINTS - 1; i >= 0; i--) begin
            if (alive[i]) begin
                first_alive = IW'(i);
                if (IW'(i) > idx_reg) begin
                    next_idx = IW'(i);
                    next_hit = 1'b1;
                end
                if (CW'(i) >= loop_reg) begin
                    out_sel = IW'(i);
                    out_hit = 1'b1;
                end
            end
        end
        if (!prev_hit) prev_idx = last_alive;
        if (!next_hit) next_idx = first_alive;
    end

    // Circular index steps over the stored points.
    assign last_idx = IW'(cnt_reg - CW'(1));
    assign inc_idx  = (idx_reg == last_idx) ? '0 : idx_reg + IW'(1);
    assign dec1_idx = (best_reg == '0) ? last_idx : best_reg - IW'(1);
    assign dec2_idx = (dec1_idx == '0) ? last_idx : dec1_idx - IW'(1);

    // Differences against the point held in pa_reg, taken from the RAM output.
    assign rd_dx = {xy_rdata[pas_pkg::XY_W-1], xy_rdata[pas_pkg::XY_W-1:pas_pkg::COORD_W]}
                 - {pa_reg[pas_pkg::XY_W-1], pa_reg[pas_pkg::XY_W-1:pas_pkg::COORD_W]};
    assign rd_dy = {xy_rdata[pas_pkg::COORD_W-1], xy_rdata[pas_pkg::COORD_W-1:0]}
                 - {pa_reg[pas_pkg::COORD_W-1], pa_reg[pas_pkg::COORD_W-1:0]};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= pas_pkg::ST_LOAD;
            cnt_reg      <= '0;
            dropped_reg  <= 1'b0;
            keep_reg     <= '0;
            removed_reg  <= '0;
            inf_reg      <= '0;
            closed_reg   <= 1'b0;
            remain_reg   <= '0;
            loop_reg     <= '0;
            post_reg     <= 1'b0;
            off_reg      <= '0;
            best_vld_reg <= 1'b0;
            cmp_vld_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            dropped_reg  <= dropped_next;
            keep_reg     <= keep_next;
            removed_reg  <= removed_next;
            inf_reg      <= inf_next;
            closed_reg   <= closed_next;
            remain_reg   <= remain_next;
            loop_reg     <= loop_next;
            post_reg     <= post_next;
            off_reg      <= off_next;
            best_vld_reg <= best_vld_next;
            cmp_vld_reg  <= cmp_vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        thr_reg       <= thr_next;
        need_reg      <= need_next;
        idx_reg       <= idx_next;
        nxt_reg       <= nxt_next;
        best_reg      <= best_next;
        cmp_idx_reg   <= cmp_idx_next;
        best_area_reg <= best_area_next;
        pa_reg        <= pa_next;
        pb_reg        <= pb_next;
        dx1_reg       <= dx1_next;
        dy1_reg       <= dy1_next;
        dx2_reg       <= dx2_next;
        dy2_reg       <= dy2_next;
        sum_mode_reg  <= sum_mode_next;
        qx_reg        <= qx_next;
        qy_reg        <= qy_next;
        eop_reg       <= eop_next;
        ovf_reg       <= ovf_next;
    end

    always_comb begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        dropped_next   = dropped_reg;
        keep_next      = keep_reg;
        removed_next   = removed_reg;
        inf_next       = inf_reg;
        closed_next    = closed_reg;
        remain_next    = remain_reg;
        loop_next      = loop_reg;
        post_next      = post_reg;
        off_next       = off_reg;
        best_vld_next  = best_vld_reg;
        cmp_vld_next   = cmp_vld_reg;
        thr_next       = thr_reg;
        need_next      = need_reg;
        idx_next       = idx_reg;
        nxt_next       = nxt_reg;
        best_next      = best_reg;
        cmp_idx_next   = cmp_idx_reg;
        best_area_next = best_area_reg;
        pa_next        = pa_reg;
        pb_next        = pb_reg;
        dx1_next       = dx1_reg;
        dy1_next       = dy1_reg;
        dx2_next       = dx2_reg;
        dy2_next       = dy2_reg;
        sum_mode_next  = sum_mode_reg;
        qx_next        = qx_reg;
        qy_next        = qy_reg;
        eop_next       = eop_reg;
        ovf_next       = ovf_reg;
        xy_we          = 1'b0;
        xy_waddr       = cnt_reg[IW-1:0];
        xy_wdata       = {s_px, s_py};
        xy_raddr       = '0;
        area_we        = 1'b0;
        area_raddr     = '0;
        area_start     = 1'b0;

        unique case (state_reg)
            pas_pkg::ST_LOAD: begin
                if (s_acc) begin
                    if (cnt_reg < CW'(MAX_POINTS)) begin
                        xy_we = 1'b1;
                        keep_next[cnt_reg[IW-1:0]] = s_keep;
                        cnt_next = cnt_reg + CW'(1);
                    end else begin
                        dropped_next = 1'b1;
                    end
                    if (s_final_point) begin
                        state_next = pas_pkg::ST_START;
                    end
                end
            end

            pas_pkg::ST_START: begin
                loop_next = '0;
                if (CW_MP'(cnt_reg) > minp_reg) begin
                    state_next = pas_pkg::ST_CLS_RD0;
                end else begin
                    state_next = pas_pkg::ST_OUT_RD;
                end
            end

            // Closed-path test: distance between first and last stored point.
            pas_pkg::ST_CLS_RD0: begin
                xy_raddr   = '0;
                state_next = pas_pkg::ST_CLS_RD1;
            end

            pas_pkg::ST_CLS_RD1: begin
                pa_next    = xy_rdata;
                xy_raddr   = last_idx;
                state_next = pas_pkg::ST_CLS_CAP;
            end

            pas_pkg::ST_CLS_CAP: begin
                dx1_next      = -rd_dx;
                dy2_next      = -rd_dx;
                dx2_next      = -rd_dy;
                dy1_next      = -rd_dy;
                sum_mode_next = 1'b1;
                area_start    = 1'b1;
                thr_next      = pas_pkg::AREA_W'({tol_sq, 1'b0});
                state_next    = pas_pkg::ST_CLS_WAIT;
            end

            pas_pkg::ST_CLS_WAIT: begin
                if (area_done) begin
                    closed_next = (cnt_reg > CW'(3)) && (area_res < pas_pkg::CLOSE_DIST_SQ);
                    inf_next    = keep_reg;
                    if (closed_next) begin
                        inf_next[0] = 1'b1;
                    end
                    if (closed_next && (minp_reg < pas_pkg::CLOSED_MIN)) begin
                        need_next = pas_pkg::CLOSED_MIN;
                    end else begin
                        need_next = minp_reg;
                    end
                    remain_next = cnt_reg;
                    loop_next   = '0;
                    state_next  = pas_pkg::ST_INIT;
                end
            end

            pas_pkg::ST_INIT: begin
                if (loop_reg == cnt_reg) begin
                    state_next = pas_pkg::ST_SCAN_START;
                end else begin
                    idx_next   = loop_reg[IW-1:0];
                    post_next  = 1'b0;
                    state_next = pas_pkg::ST_RC_CHK;
                end
            end

            // Area refresh of idx_reg against its nearest alive neighbours.
            pas_pkg::ST_RC_CHK: begin
                if (removed_reg[idx_reg] || inf_reg[idx_reg]) begin
                    state_next = pas_pkg::ST_RC_RET;
                end else if ((prev_idx == idx_reg) || (next_idx == idx_reg)
                             || (prev_idx == next_idx)) begin
                    inf_next[idx_reg] = 1'b1;
                    state_next        = pas_pkg::ST_RC_RET;
                end else begin
                    xy_raddr   = prev_idx;
                    nxt_next   = next_idx;
                    state_next = pas_pkg::ST_RC_RA;
                end
            end

            pas_pkg::ST_RC_RA: begin
                pa_next    = xy_rdata;
                xy_raddr   = idx_reg;
                state_next = pas_pkg::ST_RC_RB;
            end

            pas_pkg::ST_RC_RB: begin
                pb_next    = xy_rdata;
                xy_raddr   = nxt_reg;
                state_next = pas_pkg::ST_RC_RC;
            end

            pas_pkg::ST_RC_RC: begin
                dx1_next = {pb_reg[pas_pkg::XY_W-1], pb_reg[pas_pkg::XY_W-1:pas_pkg::COORD_W]}
                         - {pa_reg[pas_pkg::XY_W-1], pa_reg[pas_pkg::XY_W-1:pas_pkg::COORD_W]};
                dy1_next = {pb_reg[pas_pkg::COORD_W-1], pb_reg[pas_pkg::COORD_W-1:0]}
                         - {pa_reg[pas_pkg::COORD_W-1], pa_reg[pas_pkg::COORD_W-1:0]};
                dx2_next      = rd_dx;
                dy2_next      = rd_dy;
                sum_mode_next = 1'b0;
                area_start    = 1'b1;
                state_next    = pas_pkg::ST_RC_WAIT;
            end

            pas_pkg::ST_RC_WAIT: begin
                if (area_done) begin
                    area_we    = 1'b1;
                    state_next = pas_pkg::ST_RC_RET;
                end
            end

            pas_pkg::ST_RC_RET: begin
                if (!post_reg) begin
                    loop_next  = loop_reg + CW'(1);
                    state_next = pas_pkg::ST_INIT;
                end else if (off_reg == pas_pkg::RECOMP_LAST_OFF) begin
                    state_next = pas_pkg::ST_SCAN_START;
                end else begin
                    off_next   = off_reg + 3'd1;
                    idx_next   = inc_idx;
                    state_next = pas_pkg::ST_RC_CHK;
                end
            end

            // Search for the smallest area below the threshold.
            pas_pkg::ST_SCAN_START: begin
                loop_next = '0;
                if (CW_MP'(remain_reg) > need_reg) begin
                    best_vld_next  = 1'b0;
                    best_area_next = thr_reg;
                    cmp_vld_next   = 1'b0;
                    state_next     = pas_pkg::ST_SCAN;
                end else begin
                    state_next = pas_pkg::ST_OUT_RD;
                end
            end

            pas_pkg::ST_SCAN: begin
                if (cmp_vld_reg && alive[cmp_idx_reg] && !inf_reg[cmp_idx_reg]
                    && (area_rdata < best_area_reg)) begin
                    best_area_next = area_rdata;
                    best_next      = cmp_idx_reg;
                    best_vld_next  = 1'b1;
                end
                if (loop_reg < cnt_reg) begin
                    area_raddr   = loop_reg[IW-1:0];
                    cmp_idx_next = loop_reg[IW-1:0];
                    cmp_vld_next = 1'b1;
                    loop_next    = loop_reg + CW'(1);
                end else begin
                    cmp_vld_next = 1'b0;
                    if (!cmp_vld_reg) begin
                        state_next = pas_pkg::ST_SCAN_END;
                    end
                end
            end

            pas_pkg::ST_SCAN_END: begin
                if (best_vld_reg) begin
                    removed_next[best_reg] = 1'b1;
                    remain_next = remain_reg - CW'(1);
                    idx_next    = dec2_idx;
                    off_next    = '0;
                    post_next   = 1'b1;
                    state_next  = pas_pkg::ST_RC_CHK;
                end else begin
                    loop_next  = '0;
                    state_next = pas_pkg::ST_OUT_RD;
                end
            end

            // Emit survivors in index order.
            pas_pkg::ST_OUT_RD: begin
                if (out_hit) begin
                    xy_raddr   = out_sel;
                    idx_next   = out_sel;
                    eop_next   = (out_sel == last_alive);
                    ovf_next   = dropped_reg;
                    state_next = pas_pkg::ST_OUT_CAP;
                end else begin
                    cnt_next     = '0;
                    dropped_next = 1'b0;
                    keep_next    = '0;
                    removed_next = '0;
                    state_next   = pas_pkg::ST_LOAD;
                end
            end

            pas_pkg::ST_OUT_CAP: begin
                qx_next    = xy_rdata[pas_pkg::XY_W-1:pas_pkg::COORD_W];
                qy_next    = xy_rdata[pas_pkg::COORD_W-1:0];
                state_next = pas_pkg::ST_OUT_WAIT;
            end

            pas_pkg::ST_OUT_WAIT: begin
                if (m_ready) begin
                    if (eop_reg) begin
                        cnt_next     = '0;
                        dropped_next = 1'b0;
                        keep_next    = '0;
                        removed_next = '0;
                        state_next   = pas_pkg::ST_LOAD;
                    end else begin
                        loop_next  = CW'(idx_reg) + CW'(1);
                        state_next = pas_pkg::ST_OUT_RD;
                    end
                end
            end

            default: begin
                state_next = pas_pkg::ST_LOAD;
            end
        endcase
    end

    assign m_valid       = (state_reg == pas_pkg::ST_OUT_WAIT);
    assign m_qx          = qx_reg;
    assign m_qy          = qy_reg;
    assign m_end_of_path = eop_reg;
    assign m_overflow    = ovf_reg;

    // The block never takes points while a result is pending.
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid))
        else $error("point accepted while a result is pending");

    // The multiply unit only finishes while the sequencer waits for it.
    a_done_waited: assert property (@(posedge aclk) disable iff (!aresetn)
        area_done |-> (state_reg == pas_pkg::ST_RC_WAIT || state_reg == pas_pkg::ST_CLS_WAIT))
        else $error("area result arrived outside a wait state");

    // After the last survivor the path store is empty again.
    a_path_cleared: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && m_end_of_path) |=> (cnt_reg == '0 && removed_reg == '0))
        else $error("path state not cleared after end of path");

    // A removal round only runs while more points remain than must be kept.
    a_scan_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == pas_pkg::ST_SCAN) |->
            (remain_reg <= cnt_reg && CW_MP'(remain_reg) > need_reg))
        else $error("removal scan with too few remaining points");

endmodule
